>>> sv/cpualu_pkg.sv
// Shared types and operation codes of the 8-bit CPU arithmetic and flag unit.
`default_nettype none

package cpualu_pkg;

   typedef enum logic [5:0] {
      CMD_ADD   = 6'd0,
      CMD_ADC   = 6'd1,
      CMD_SUB   = 6'd2,
      CMD_SBC   = 6'd3,
      CMD_AND   = 6'd4,
      CMD_XOR   = 6'd5,
      CMD_OR    = 6'd6,
      CMD_CP    = 6'd7,
      CMD_INC8  = 6'd8,
      CMD_DEC8  = 6'd9,
      CMD_ADD16 = 6'd10,
      CMD_ADDSP = 6'd11,
      CMD_INC16 = 6'd12,
      CMD_DEC16 = 6'd13,
      CMD_RLCA  = 6'd14,
      CMD_RRCA  = 6'd15,
      CMD_RLA   = 6'd16,
      CMD_RRA   = 6'd17,
      CMD_RLC   = 6'd18,
      CMD_RRC   = 6'd19,
      CMD_RL    = 6'd20,
      CMD_RR    = 6'd21,
      CMD_SLA   = 6'd22,
      CMD_SRA   = 6'd23,
      CMD_SWAP  = 6'd24,
      CMD_SRL   = 6'd25,
      CMD_BIT   = 6'd26,
      CMD_RES   = 6'd27,
      CMD_SET   = 6'd28,
      CMD_DAA   = 6'd29,
      CMD_CPL   = 6'd30,
      CMD_SCF   = 6'd31,
      CMD_CCF   = 6'd32
   } command_type;

   // flag bit positions within a flag nibble
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 24;

   // packed with the first field in the highest bits
   typedef struct packed {
      logic [3:0]  flags_in;
      logic [2:0]  bit_index;
      logic [15:0] operand_b;
      logic [15:0] operand_a;
      logic [5:0]  command;
   } request_type;

   typedef struct packed {
      logic        writes_result;
      logic [3:0]  flags_out;
      logic [15:0] result;
   } response_type;

endpackage

`default_nettype wire

>>> sv/cpualu_core.sv
// Combinational datapath: result, new flags and write-back mark for one request.
`default_nettype none

module cpualu_core
   import cpualu_pkg::*;
(
   input  request_type  req,
   output response_type rsp
);

   logic [7:0]  a, b;
   logic        cin;
   logic [3:0]  f;
   logic [8:0]  add9, adc9, sub9, sbc9;
   logic [4:0]  add_h5, adc_h5, sub_h5, sbc_h5;
   logic [16:0] add17;
   logic [12:0] add_h13;
   logic [15:0] sp_sum, inc16, dec16;
   logic [7:0]  bit_mask;
   logic [7:0]  daa_adj;
   logic        daa_c;
   logic [7:0]  daa_r;
   logic [7:0]  r8;
   logic [15:0] r16;
   logic        use16;
   logic [3:0]  nf;
   logic        wr;

   assign a   = req.operand_a[7:0];
   assign b   = req.operand_b[7:0];
   assign f   = req.flags_in;
   assign cin = req.flags_in[FLAG_C];

   assign add9   = {1'b0, a} + {1'b0, b};
   assign adc9   = {1'b0, a} + {1'b0, b} + {8'h00, cin};
   assign sub9   = {1'b0, a} - {1'b0, b};
   assign sbc9   = {1'b0, a} - {1'b0, b} - {8'h00, cin};
   assign add_h5 = {1'b0, a[3:0]} + {1'b0, b[3:0]};
   assign adc_h5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
   assign sub_h5 = {1'b0, a[3:0]} - {1'b0, b[3:0]};
   assign sbc_h5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cin};

   assign add17   = {1'b0, req.operand_a} + {1'b0, req.operand_b};
   assign add_h13 = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
   assign sp_sum  = req.operand_a + {{8{b[7]}}, b};
   assign inc16   = req.operand_a + 16'd1;
   assign dec16   = req.operand_a - 16'd1;

   assign bit_mask = 8'd1 << req.bit_index;

   // decimal adjust: subtract after a subtraction, add after an addition
   always_comb begin
      daa_adj = 8'h00;
      daa_c   = 1'b0;
      if (f[FLAG_N]) begin
         if (f[FLAG_H]) daa_adj[3:0] = 4'h6;
         if (f[FLAG_C]) begin
            daa_adj[7:4] = 4'h6;
            daa_c        = 1'b1;
         end
         daa_r = a - daa_adj;
      end else begin
         if (f[FLAG_H] || (a[3:0] > 4'd9)) daa_adj[3:0] = 4'h6;
         if (f[FLAG_C] || (a > 8'h99)) begin
            daa_adj[7:4] = 4'h6;
            daa_c        = 1'b1;
         end
         daa_r = a + daa_adj;
      end
   end

   always_comb begin
      r8    = 8'h00;
      r16   = 16'h0000;
      use16 = 1'b0;
      nf    = f;
      wr    = 1'b1;
      unique case (req.command)
         CMD_ADD: begin
            r8 = add9[7:0];
            nf = {r8 == 8'h00, 1'b0, add_h5[4], add9[8]};
         end
         CMD_ADC: begin
            r8 = adc9[7:0];
            nf = {r8 == 8'h00, 1'b0, adc_h5[4], adc9[8]};
         end
         CMD_SUB, CMD_CP: begin
            nf = {sub9[7:0] == 8'h00, 1'b1, sub_h5[4], sub9[8]};
            if (req.command == CMD_CP) begin
               wr = 1'b0;
            end else begin
               r8 = sub9[7:0];
            end
         end
         CMD_SBC: begin
            r8 = sbc9[7:0];
            nf = {r8 == 8'h00, 1'b1, sbc_h5[4], sbc9[8]};
         end
         CMD_AND: begin
            r8 = a & b;
            nf = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
         end
         CMD_XOR: begin
            r8 = a ^ b;
            nf = {r8 == 8'h00, 3'b000};
         end
         CMD_OR: begin
            r8 = a | b;
            nf = {r8 == 8'h00, 3'b000};
         end
         CMD_INC8: begin
            r8 = a + 8'd1;
            nf = {r8 == 8'h00, 1'b0, a[3:0] == 4'hF, cin};
         end
         CMD_DEC8: begin
            r8 = a - 8'd1;
            nf = {r8 == 8'h00, 1'b1, a[3:0] == 4'h0, cin};
         end
         CMD_ADD16: begin
            use16 = 1'b1;
            r16   = add17[15:0];
            nf    = {f[FLAG_Z], 1'b0, add_h13[12], add17[16]};
         end
         CMD_ADDSP: begin
            use16 = 1'b1;
            r16   = sp_sum;
            nf    = {2'b00, add_h5[4], add9[8]};
         end
         CMD_INC16: begin
            use16 = 1'b1;
            r16   = inc16;
         end
         CMD_DEC16: begin
            use16 = 1'b1;
            r16   = dec16;
         end
         CMD_RLCA: begin
            r8 = {a[6:0], a[7]};
            nf = {3'b000, a[7]};
         end
         CMD_RRCA: begin
            r8 = {a[0], a[7:1]};
            nf = {3'b000, a[0]};
         end
         CMD_RLA: begin
            r8 = {a[6:0], cin};
            nf = {3'b000, a[7]};
         end
         CMD_RRA: begin
            r8 = {cin, a[7:1]};
            nf = {3'b000, a[0]};
         end
         CMD_RLC: begin
            r8 = {a[6:0], a[7]};
            nf = {r8 == 8'h00, 2'b00, a[7]};
         end
         CMD_RRC: begin
            r8 = {a[0], a[7:1]};
            nf = {r8 == 8'h00, 2'b00, a[0]};
         end
         CMD_RL: begin
            r8 = {a[6:0], cin};
            nf = {r8 == 8'h00, 2'b00, a[7]};
         end
         CMD_RR: begin
            r8 = {cin, a[7:1]};
            nf = {r8 == 8'h00, 2'b00, a[0]};
         end
         CMD_SLA: begin
            r8 = {a[6:0], 1'b0};
            nf = {r8 == 8'h00, 2'b00, a[7]};
         end
         CMD_SRA: begin
            r8 = {a[7], a[7:1]};
            nf = {r8 == 8'h00, 2'b00, a[0]};
         end
         CMD_SWAP: begin
            r8 = {a[3:0], a[7:4]};
            nf = {r8 == 8'h00, 3'b000};
         end
         CMD_SRL: begin
            r8 = {1'b0, a[7:1]};
            nf = {r8 == 8'h00, 2'b00, a[0]};
         end
         CMD_BIT: begin
            wr = 1'b0;
            nf = {~a[req.bit_index], 1'b0, 1'b1, cin};
         end
         CMD_RES: begin
            r8 = a & ~bit_mask;
         end
         CMD_SET: begin
            r8 = a | bit_mask;
         end
         CMD_DAA: begin
            r8 = daa_r;
            nf = {r8 == 8'h00, f[FLAG_N], 1'b0, daa_c};
         end
         CMD_CPL: begin
            r8 = ~a;
            nf = {f[FLAG_Z], 1'b1, 1'b1, f[FLAG_C]};
         end
         CMD_SCF: begin
            wr = 1'b0;
            nf = {f[FLAG_Z], 3'b001};
         end
         CMD_CCF: begin
            wr = 1'b0;
            nf = {f[FLAG_Z], 2'b00, ~cin};
         end
         default: begin
            // unused codes: pass the flags through, nothing written
            wr = 1'b0;
         end
      endcase
   end

   assign rsp.result        = use16 ? r16 : {8'h00, r8};
   assign rsp.flags_out     = nf;
   assign rsp.writes_result = wr;

endmodule

`default_nettype wire

>>> sv/cpu_alu_with_flags_top.sv
// Top level: request register, ALU datapath and response register.
//
// channel | dir | ports            | payload (low bit up)
// --------+-----+------------------+-----------------------------------------------
// req     | in  | req_tvalid/ready | command, operand_a, operand_b, bit_index, flags_in
// rsp     | out | rsp_tvalid/ready | result, flags_out, writes_result
//
// An accepted request is held in the request register, then passes through the
// datapath into the response register, from which the valid response is taken.
// One request is accepted per cycle while responses are taken.
// Reset is synchronous and empties both registers.
// A stalled response holds; the request register still takes one more request if it is empty.
`default_nettype none

module cpu_alu_with_flags_top
   import cpualu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // command[5:0], operand_a[21:6], operand_b[37:22], bit_index[40:38],
   // flags_in[44:41], zero fill[47:45]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // result[15:0], flags_out[19:16], writes_result[20], zero fill[23:21]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   logic         s1_valid_ff, s1_valid_in;
   request_type  s1_req_ff;
   logic         out_valid_ff, out_valid_in;
   response_type out_rsp_ff;
   response_type core_rsp;
   logic         out_ready;
   logic         s1_ready;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign s1_ready   = !s1_valid_ff || out_ready;
   assign req_tready = s1_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_ready) s1_valid_in = req_tvalid;
      out_valid_in = out_valid_ff;
      if (out_ready) out_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: load on advance only
   always_ff @(posedge clock) begin
      if (s1_ready && req_tvalid) s1_req_ff <= request_type'(req_tdata[$bits(request_type)-1:0]);
      if (out_ready && s1_valid_ff) out_rsp_ff <= core_rsp;
   end

   cpualu_core u_core (
      .req (s1_req_ff),
      .rsp (core_rsp)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - $bits(response_type)){1'b0}}, out_rsp_ff};

endmodule

`default_nettype wire

>>> sv/cpualu_checker.sv
// Port-level checks on the ALU top level, with the bind that attaches them.
`default_nettype none

module cpualu_checker
   import cpualu_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[20] |-> rsp_tdata[15:0] == 16'h0000)
      else $error("non-written response carries a result");

   // an accepted request reaches the output via the request and response registers unless stalled
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 (!rsp_tvalid || rsp_tready) |=> rsp_tvalid)
      else $error("accepted request did not reach the response register");

   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:21] == 3'b000)
      else $error("response fill bits not zero");

endmodule

bind cpu_alu_with_flags_top cpualu_checker u_cpualu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
